// ===== rtl/core/stq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package stq_pkg;

  localparam int unsigned VALUE_W = 64;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned LEN_W   = IDX_W + 1;
  localparam int unsigned MSB_W   = 4;

  localparam logic [1:0] OP_MIN = 2'd0;
  localparam logic [1:0] OP_MAX = 2'd1;
  localparam logic [1:0] OP_AND = 2'd2;
  localparam logic [1:0] OP_OR  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_RANGE = 2'd1;
  localparam logic [1:0] ST_NOT_READY = 2'd2;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [VALUE_W-1:0] value;
    logic               last;
    logic [IDX_W-1:0]   left;
    logic [IDX_W-1:0]   right;
  } in_t;

  typedef struct packed {
    logic [VALUE_W-1:0] result;
    logic [1:0]         status;
  } out_t;

  typedef struct packed {
    logic accept;
    logic build_init;
    logic build_rd;
    logic build_wr;
  } cmd_t;

  typedef struct packed {
    logic need_build;
    logic entry_last;
    logic level_last;
  } sts_t;

  function automatic logic [VALUE_W-1:0] combine(input logic [1:0] op,
                                                 input logic [VALUE_W-1:0] a,
                                                 input logic [VALUE_W-1:0] b);
    logic a_less;
    logic [VALUE_W-1:0] r;
    a_less = $signed(a) < $signed(b);
    unique case (op)
      OP_MIN:  r = a_less ? a : b;
      OP_MAX:  r = a_less ? b : a;
      OP_AND:  r = a & b;
      default: r = a | b;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/stq_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module stq_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] ra_addr,
  output logic      [WIDTH-1:0]         ra_data,
  input  wire logic [$clog2(DEPTH)-1:0] rb_addr,
  output logic      [WIDTH-1:0]         rb_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end
endmodule
`default_nettype wire

// ===== rtl/core/stq_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module stq_ctrl
  import stq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire sts_t sts,
  output cmd_t      cmd,
  output logic      busy
);
  typedef enum logic [2:0] {
    S_IDLE     = 3'b001,
    S_BUILD_RD = 3'b010,
    S_BUILD_WR = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    unique case (state)
      S_IDLE: begin
        cmd.accept     = start;
        cmd.build_init = start && sts.need_build;
        if (start && sts.need_build) begin
          state_next = S_BUILD_RD;
        end
      end
      S_BUILD_RD: begin
        cmd.build_rd = 1'b1;
        state_next   = S_BUILD_WR;
      end
      S_BUILD_WR: begin
        cmd.build_wr = 1'b1;
        state_next   = (sts.entry_last && sts.level_last) ? S_IDLE : S_BUILD_RD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);
endmodule
`default_nettype wire

// ===== rtl/core/stq_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module stq_dp
  import stq_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = 1024,
  parameter int unsigned LEVELS       = 11
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cmd_t       cmd,
  input  wire in_t        item,
  input  wire logic       op_we,
  input  wire logic [1:0] op_wdata,
  output sts_t            sts,
  output logic            done,
  output out_t            res
);
  localparam int unsigned IDXW  = $clog2(MAX_ELEMENTS);
  localparam int unsigned CNTW  = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned LVLW  = $clog2(LEVELS);
  localparam int unsigned LCW   = $clog2(LEVELS + 1);
  localparam int unsigned AW    = LVLW + IDXW;
  localparam int unsigned BW    = CNTW + 1;
  localparam int unsigned DEPTH = LEVELS << IDXW;

  logic [1:0]      op_select;
  logic [CNTW-1:0] count;
  logic [LCW-1:0]  lvl_count;
  logic            ready;
  logic [LVLW-1:0] lvl;
  logic [IDXW-1:0] idx;
  logic            q_valid;
  logic [1:0]      q_status;

  logic [CNTW-1:0] count_base, count_after;
  logic            has_room;
  logic [LCW-1:0]  lc_calc;
  logic            load_acc, query_acc;

  logic [LEN_W-1:0] q_len, b_idx;
  logic [MSB_W-1:0] msb;
  logic [LCW-1:0]   lc_m1;
  logic [LVLW-1:0]  j_q;
  logic [1:0]       status_calc;

  logic [IDXW:0]      half;
  logic [IDXW-1:0]    idx_b;
  logic               we;
  logic [AW-1:0]      waddr, ra_addr, rb_addr;
  logic [VALUE_W-1:0] wdata, ra_data, rb_data;

  assign load_acc    = cmd.accept && (item.mode == MODE_LOAD);
  assign query_acc   = cmd.accept && (item.mode == MODE_QUERY);
  assign count_base  = ready ? '0 : count;
  assign has_room    = (32'(count_base) < MAX_ELEMENTS);
  assign count_after = count_base + CNTW'(has_room);

  always_comb begin
    lc_calc = '0;
    for (int j = 0; j < LEVELS; j++) begin
      if ((64'(1) << j) <= 64'(count_after)) begin
        lc_calc = lc_calc + LCW'(1);
      end
    end
  end

  assign sts.need_build = (item.mode == MODE_LOAD) && item.last && (lc_calc >= LCW'(2));
  assign sts.entry_last = (BW'(idx) + (BW'(1) << lvl)) == BW'(count);
  assign sts.level_last = (LCW'(lvl) + LCW'(1)) == lvl_count;

  // query address path: level = floor(log2(len)) capped at the top built level
  assign q_len = LEN_W'(item.right) - LEN_W'(item.left) + LEN_W'(1);
  always_comb begin
    msb = '0;
    for (int i = 0; i < LEN_W; i++) begin
      if (q_len[i]) begin
        msb = MSB_W'(i);
      end
    end
  end
  assign lc_m1 = lvl_count - LCW'(1);
  assign j_q   = (32'(msb) > 32'(lc_m1)) ? LVLW'(lc_m1) : LVLW'(msb);
  assign b_idx = LEN_W'(item.right) + LEN_W'(1) - (LEN_W'(1) << j_q);

  always_comb begin
    priority if (!ready) begin
      status_calc = ST_NOT_READY;
    end else if ((item.left > item.right) || (32'(item.right) >= 32'(count))) begin
      status_calc = ST_BAD_RANGE;
    end else begin
      status_calc = ST_OK;
    end
  end

  assign half  = (IDXW + 1)'(1) << (lvl - LVLW'(1));
  assign idx_b = IDXW'((IDXW + 1)'(idx) + half);

  always_comb begin
    if (cmd.build_rd) begin
      ra_addr = {LVLW'(lvl - LVLW'(1)), idx};
      rb_addr = {LVLW'(lvl - LVLW'(1)), idx_b};
    end else begin
      ra_addr = {j_q, IDXW'(item.left)};
      rb_addr = {j_q, IDXW'(b_idx)};
    end
  end

  assign we    = (load_acc && has_room) || cmd.build_wr;
  assign waddr = cmd.build_wr ? {lvl, idx} : {LVLW'(0), IDXW'(count_base)};
  assign wdata = cmd.build_wr ? combine(op_select, ra_data, rb_data) : item.value;

  stq_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .ra_addr (ra_addr),
    .ra_data (ra_data),
    .rb_addr (rb_addr),
    .rb_data (rb_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      op_select <= OP_MIN;
      count     <= '0;
      lvl_count <= '0;
      ready     <= 1'b0;
      q_valid   <= 1'b0;
    end else begin
      if (op_we) begin
        op_select <= op_wdata;
      end
      q_valid <= query_acc;
      if (load_acc) begin
        count <= count_after;
        if (item.last && (count_after != '0)) begin
          lvl_count <= lc_calc;
          ready     <= 1'b1;
        end else begin
          ready <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (query_acc) begin
      q_status <= status_calc;
    end
    if (cmd.build_init) begin
      lvl <= LVLW'(1);
      idx <= '0;
    end else if (cmd.build_wr) begin
      if (sts.entry_last) begin
        lvl <= lvl + LVLW'(1);
        idx <= '0;
      end else begin
        idx <= idx + IDXW'(1);
      end
    end
  end

  assign done       = q_valid;
  assign res.status = q_status;
  assign res.result = (q_status == ST_OK) ? combine(op_select, ra_data, rb_data) : '0;
endmodule
`default_nettype wire

// ===== rtl/core/sparse_table_range_query.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Query: result strobed on done the next cycle after acceptance; one query per cycle while not busy.
// Load: elements are written to level 0 of the store; no result.
// Load marked last: if two or more levels are needed, busy while the build reads two
// entries and writes one through the dual-read store per entry.
// Synchronous active-high reset clears counts and the ready flag; the store is not cleared.
// Results cannot be stalled by the receiver.
module sparse_table_range_query
  import stq_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = 1024,
  parameter int unsigned LEVELS       = 11
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire in_t        item,
  output logic            done,
  output out_t            res,
  input  wire logic       op_we,
  input  wire logic [1:0] op_wdata
);
  cmd_t cmd;
  sts_t sts;

  stq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  stq_dp #(.MAX_ELEMENTS(MAX_ELEMENTS), .LEVELS(LEVELS)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .item     (item),
    .op_we    (op_we),
    .op_wdata (op_wdata),
    .sts      (sts),
    .done     (done),
    .res      (res)
  );
endmodule
`default_nettype wire

// ===== rtl/core/stq_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module stq_checker
  import stq_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire in_t  item,
  input wire logic done,
  input wire out_t res
);
  // every accepted query yields exactly one transfer next cycle
  a_query_done: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (item.mode == MODE_QUERY) |=> done)
    else $error("query without result");

  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (item.mode == MODE_LOAD) |=> !done)
    else $error("result after load");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (res.status == ST_OK) || (res.status == ST_BAD_RANGE) ||
             (res.status == ST_NOT_READY))
    else $error("bad status");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    done && (res.status != ST_OK) |-> (res.result == '0))
    else $error("nonzero result on error");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !$past(start) |-> !done)
    else $error("spurious result");
endmodule

bind sparse_table_range_query stq_checker u_chk (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .item  (item),
  .done  (done),
  .res   (res)
);
`default_nettype wire
